// File: hw/rtl/assert_macros.svh
// Assertion macros for the sorted key table RTL.
// Included by modules that carry concurrent assertions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SKT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SKT_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define SKT_ASSERT(lbl, clk, rstn, prop)
`define SKT_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// File: hw/rtl/skt_pkg.sv
// Shared types and constants of the sorted key table.
// No dependencies; used by skt_ctrl, skt_datapath and the top level.
`default_nettype none
package skt_pkg;

  localparam int unsigned DefaultDepth = 1024;
  localparam int unsigned OutW         = 11;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_SORT   = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_e;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] value;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_BLD_LOAD,
    OP_CUR_LOAD,
    OP_SIFT_RC,
    OP_SIFT_C1,
    OP_SIFT_C2,
    OP_SIFT_DEC,
    OP_EXT_RD_I,
    OP_EXT_RD_0,
    OP_EXT_WR,
    OP_QL_STEP,
    OP_QL_CMP,
    OP_QL_FIN,
    OP_QU_STEP,
    OP_QU_CMP,
    OP_QU_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic small_table;
    logic i_zero;
    logic child_lt_lim;
    logic child1_lt_lim;
    logic best_is_root;
    logic ext_phase;
    logic lo_lt_hx;
    logic lo_lt_n;
    logic key_eq;
  } status_t;

endpackage
`default_nettype wire

// File: hw/rtl/skt_ctrl.sv
// Sequencer of the sorted key table: handshakes, sort and search steps.
// Depends on skt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module skt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      func_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire skt_pkg::status_t status_i,
  output skt_pkg::cmd_t        cmd_o
);
  import skt_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_BLD  = 17'h00002,
    ST_CUR  = 17'h00004,
    ST_SRC  = 17'h00008,
    ST_SC1  = 17'h00010,
    ST_SC2  = 17'h00020,
    ST_SDEC = 17'h00040,
    ST_ECHK = 17'h00080,
    ST_ERDI = 17'h00100,
    ST_ERD0 = 17'h00200,
    ST_EWR  = 17'h00400,
    ST_QLS  = 17'h00800,
    ST_QLC  = 17'h01000,
    ST_QLF  = 17'h02000,
    ST_QUS  = 17'h04000,
    ST_QUC  = 17'h08000,
    ST_QUF  = 17'h10000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;
  logic   out_valid_q;
  logic   load_out;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE) && !fin_q;
  assign accept      = in_valid_i && in_ready_o;
  assign load_out    = fin_q && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    fin_d        = fin_q && !load_out;
    cmd_o.op       = OP_NOP;
    cmd_o.load_out = load_out;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.op = OP_ACCEPT;
          case (func_i)
            FUNC_SORT: begin
              if (status_i.small_table) begin
                fin_d = 1'b1;
              end else begin
                state_d = ST_BLD;
              end
            end
            FUNC_QUERY: state_d = ST_QLS;
            default:    fin_d = 1'b1;
          endcase
        end
      end
      ST_BLD: begin
        cmd_o.op = OP_BLD_LOAD;
        state_d  = status_i.i_zero ? ST_ECHK : ST_CUR;
      end
      ST_CUR: begin
        cmd_o.op = OP_CUR_LOAD;
        state_d  = ST_SRC;
      end
      ST_SRC: begin
        cmd_o.op = OP_SIFT_RC;
        state_d  = status_i.child_lt_lim ? ST_SC1 : ST_SDEC;
      end
      ST_SC1: begin
        cmd_o.op = OP_SIFT_C1;
        state_d  = status_i.child1_lt_lim ? ST_SC2 : ST_SDEC;
      end
      ST_SC2: begin
        cmd_o.op = OP_SIFT_C2;
        state_d  = ST_SDEC;
      end
      ST_SDEC: begin
        cmd_o.op = OP_SIFT_DEC;
        if (!status_i.best_is_root) begin
          state_d = ST_SRC;
        end else if (status_i.ext_phase) begin
          state_d = ST_ECHK;
        end else begin
          state_d = ST_BLD;
        end
      end
      ST_ECHK: begin
        if (status_i.i_zero) begin
          state_d = ST_IDLE;
          fin_d   = 1'b1;
        end else begin
          state_d = ST_ERDI;
        end
      end
      ST_ERDI: begin
        cmd_o.op = OP_EXT_RD_I;
        state_d  = ST_ERD0;
      end
      ST_ERD0: begin
        cmd_o.op = OP_EXT_RD_0;
        state_d  = ST_EWR;
      end
      ST_EWR: begin
        cmd_o.op = OP_EXT_WR;
        state_d  = ST_SRC;
      end
      ST_QLS: begin
        cmd_o.op = OP_QL_STEP;
        if (status_i.lo_lt_hx) begin
          state_d = ST_QLC;
        end else if (status_i.lo_lt_n) begin
          state_d = ST_QLF;
        end else begin
          state_d = ST_IDLE;
          fin_d   = 1'b1;
        end
      end
      ST_QLC: begin
        cmd_o.op = OP_QL_CMP;
        state_d  = ST_QLS;
      end
      ST_QLF: begin
        cmd_o.op = OP_QL_FIN;
        if (status_i.key_eq) begin
          state_d = ST_QUS;
        end else begin
          state_d = ST_IDLE;
          fin_d   = 1'b1;
        end
      end
      ST_QUS: begin
        cmd_o.op = OP_QU_STEP;
        state_d  = status_i.lo_lt_hx ? ST_QUC : ST_QUF;
      end
      ST_QUC: begin
        cmd_o.op = OP_QU_CMP;
        state_d  = ST_QUS;
      end
      ST_QUF: begin
        cmd_o.op = OP_QU_FIN;
        state_d  = ST_IDLE;
        fin_d    = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `SKT_ASSERT_NEXT(a_load_sets_valid, clk_i, rst_ni, load_out, out_valid_q && !fin_q)
  `SKT_ASSERT(a_busy_blocks_input, clk_i, rst_ni, (state_q != ST_IDLE) |-> !in_ready_o)
  `SKT_ASSERT_NEXT(a_fin_only_idle, clk_i, rst_ni, fin_q, state_q == ST_IDLE)

endmodule
`default_nettype wire

// File: hw/rtl/skt_datapath.sv
// Datapath of the sorted key table: entry memory, heap sort and search registers.
// Depends on skt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module skt_datapath #(
  parameter int unsigned TABLE_DEPTH = skt_pkg::DefaultDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire skt_pkg::cmd_t                cmd_i,
  output skt_pkg::status_t                  status_o,
  input  wire logic [1:0]                   func_i,
  input  wire logic [63:0]                  key_high_i,
  input  wire logic [63:0]                  key_low_i,
  input  wire logic [63:0]                  entry_value_i,
  output logic [skt_pkg::OutW-1:0]          match_count_o,
  output logic signed [skt_pkg::OutW-1:0]   first_index_o,
  output logic signed [skt_pkg::OutW-1:0]   last_index_o,
  output logic                              overflow_o,
  output logic [skt_pkg::OutW-1:0]          entries_held_o
);
  import skt_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = CW + 1;

  entry_t          mem_q [TABLE_DEPTH];
  entry_t          rdata_q;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  entry_t          wr_data;

  logic [CW-1:0]   count_q;
  logic            ext_q;
  logic [CW-1:0]   i_q, lim_q, root_q, best_idx_q;
  logic [CW-1:0]   lo_q, hx_q, mid_q, l_q;
  logic [63:0]     qkh_q, qkl_q;
  entry_t          cur_q, best_q;
  logic [OutW-1:0] res_count_q;
  logic [OutW-1:0] res_first_q, res_last_q;
  logic            res_ovf_q;

  logic            full;
  logic [CW:0]     child, child1;
  logic [CW-1:0]   i_m1, diff, mid, hx_m1;
  logic            key_eq, key_gt, ord_gt;
  logic signed [IW-1:0] l_s, r_s, cnt_s;

  assign full    = (count_q == CW'(TABLE_DEPTH));
  assign child   = {root_q, 1'b1};
  assign child1  = child + (CW+1)'(1);
  assign i_m1    = i_q - CW'(1);
  assign diff    = hx_q - lo_q - CW'(1);
  assign mid     = lo_q + (diff >> 1);
  assign hx_m1   = hx_q - CW'(1);
  assign key_eq  = (rdata_q.key_high == qkh_q) && (rdata_q.key_low == qkl_q);
  assign key_gt  = {rdata_q.key_high, rdata_q.key_low} > {qkh_q, qkl_q};
  assign ord_gt  = rdata_q > best_q;
  assign l_s     = $signed({1'b0, l_q});
  assign r_s     = (hx_q > l_q && key_eq) ? $signed({1'b0, hx_m1}) : l_s - IW'(1);
  assign cnt_s   = r_s - l_s + IW'(1);

  assign status_o.small_table   = (count_q < CW'(2));
  assign status_o.i_zero        = (i_q == '0);
  assign status_o.child_lt_lim  = (child < {1'b0, lim_q});
  assign status_o.child1_lt_lim = (child1 < {1'b0, lim_q});
  assign status_o.best_is_root  = (best_idx_q == root_q);
  assign status_o.ext_phase     = ext_q;
  assign status_o.lo_lt_hx      = (lo_q < hx_q);
  assign status_o.lo_lt_n       = (lo_q < count_q);
  assign status_o.key_eq        = key_eq;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = cur_q;
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        wr_en   = (func_i == FUNC_APPEND) && !full;
        wr_addr = count_q[AW-1:0];
        wr_data = entry_t'{key_high: key_high_i, key_low: key_low_i, value: entry_value_i};
      end
      OP_BLD_LOAD: begin
        rd_en   = !status_o.i_zero;
        rd_addr = i_m1[AW-1:0];
      end
      OP_SIFT_RC: begin
        rd_en   = status_o.child_lt_lim;
        rd_addr = child[AW-1:0];
      end
      OP_SIFT_C1: begin
        rd_en   = status_o.child1_lt_lim;
        rd_addr = child1[AW-1:0];
      end
      OP_SIFT_DEC: begin
        wr_en   = 1'b1;
        wr_addr = root_q[AW-1:0];
        wr_data = status_o.best_is_root ? cur_q : best_q;
      end
      OP_EXT_RD_I: begin
        rd_en   = 1'b1;
        rd_addr = i_q[AW-1:0];
      end
      OP_EXT_RD_0: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      OP_EXT_WR: begin
        wr_en   = 1'b1;
        wr_addr = i_q[AW-1:0];
        wr_data = rdata_q;
      end
      OP_QL_STEP: begin
        rd_en   = status_o.lo_lt_hx || status_o.lo_lt_n;
        rd_addr = status_o.lo_lt_hx ? mid[AW-1:0] : lo_q[AW-1:0];
      end
      OP_QU_STEP: begin
        rd_en   = status_o.lo_lt_hx || (hx_q > l_q);
        rd_addr = status_o.lo_lt_hx ? mid[AW-1:0] : hx_m1[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ext_q   <= 1'b0;
    end else begin
      if (cmd_i.op == OP_ACCEPT) begin
        ext_q <= 1'b0;
        if (func_i == FUNC_CLEAR) begin
          count_q <= '0;
        end else if (func_i == FUNC_APPEND && !full) begin
          count_q <= count_q + CW'(1);
        end
      end else if (cmd_i.op == OP_BLD_LOAD && status_o.i_zero) begin
        ext_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        qkh_q       <= key_high_i;
        qkl_q       <= key_low_i;
        res_count_q <= '0;
        res_first_q <= '1;
        res_last_q  <= '1;
        res_ovf_q   <= (func_i == FUNC_APPEND) && full;
        i_q         <= count_q >> 1;
        lim_q       <= count_q;
        lo_q        <= '0;
        hx_q        <= count_q;
      end
      OP_BLD_LOAD: begin
        if (status_o.i_zero) begin
          i_q <= count_q - CW'(1);
        end else begin
          i_q    <= i_m1;
          root_q <= i_m1;
        end
      end
      OP_CUR_LOAD: cur_q <= rdata_q;
      OP_SIFT_RC: begin
        best_q     <= cur_q;
        best_idx_q <= root_q;
      end
      OP_SIFT_C1: begin
        if (ord_gt) begin
          best_q     <= rdata_q;
          best_idx_q <= child[CW-1:0];
        end
      end
      OP_SIFT_C2: begin
        if (ord_gt) begin
          best_q     <= rdata_q;
          best_idx_q <= child1[CW-1:0];
        end
      end
      OP_SIFT_DEC: begin
        if (!status_o.best_is_root) begin
          root_q <= best_idx_q;
        end else if (ext_q) begin
          i_q <= i_m1;
        end
      end
      OP_EXT_RD_I: begin
        root_q <= '0;
        lim_q  <= i_q;
      end
      OP_EXT_RD_0: cur_q <= rdata_q;
      OP_QL_STEP, OP_QU_STEP: mid_q <= mid;
      OP_QL_CMP: begin
        if (key_gt || key_eq) begin
          hx_q <= mid_q;
        end else begin
          lo_q <= mid_q + CW'(1);
        end
      end
      OP_QU_CMP: begin
        if (!key_gt) begin
          lo_q <= mid_q + CW'(1);
        end else begin
          hx_q <= mid_q;
        end
      end
      OP_QL_FIN: begin
        l_q  <= lo_q;
        hx_q <= count_q;
      end
      OP_QU_FIN: begin
        res_first_q <= OutW'(l_s);
        res_last_q  <= OutW'(r_s);
        res_count_q <= OutW'(cnt_s);
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      match_count_o  <= res_count_q;
      first_index_o  <= $signed(res_first_q);
      last_index_o   <= $signed(res_last_q);
      overflow_o     <= res_ovf_q;
      entries_held_o <= OutW'(count_q);
    end
  end

  `SKT_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CW'(TABLE_DEPTH))
  `SKT_ASSERT_NEXT(a_append_grows, clk_i, rst_ni, (cmd_i.op == OP_ACCEPT && func_i == FUNC_APPEND && !full), count_q == $past(count_q) + CW'(1))
  `SKT_ASSERT(a_sift_in_range, clk_i, rst_ni, (cmd_i.op == OP_SIFT_C1) |-> (child < {1'b0, lim_q}))

endmodule
`default_nettype wire

// File: hw/rtl/sorted_key_table_equal_range.sv
// Sorted key table with equal-range query. Entries of a 128-bit key and a
// 64-bit value live in a single-port-read, single-port-write memory of
// TABLE_DEPTH rows with registered read data. A query runs two binary
// searches, each probe an address step and then a compare step. Sort is an
// in-place heap sort through the same memory port. One item is worked at a
// time; the next item is taken while a finished result waits on the output.
// Depends on skt_pkg, skt_ctrl and skt_datapath.
`default_nettype none
module sorted_key_table_equal_range #(
  parameter int unsigned TABLE_DEPTH = skt_pkg::DefaultDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  func_i,
  input  wire logic [63:0]                 key_high_i,
  input  wire logic [63:0]                 key_low_i,
  input  wire logic [63:0]                 entry_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [skt_pkg::OutW-1:0]         match_count_o,
  output logic signed [skt_pkg::OutW-1:0]  first_index_o,
  output logic signed [skt_pkg::OutW-1:0]  last_index_o,
  output logic                             overflow_o,
  output logic [skt_pkg::OutW-1:0]         entries_held_o
);
  import skt_pkg::*;

  cmd_t    cmd;
  status_t status;

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  skt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .func_i         (func_i),
    .key_high_i     (key_high_i),
    .key_low_i      (key_low_i),
    .entry_value_i  (entry_value_i),
    .match_count_o  (match_count_o),
    .first_index_o  (first_index_o),
    .last_index_o   (last_index_o),
    .overflow_o     (overflow_o),
    .entries_held_o (entries_held_o)
  );

endmodule
`default_nettype wire
